/* src/gdp_pkg.sv */
// Package for the genus-2 divisor block: residue types, unit command struct,
// and the narrow modular helper functions used by the serial units and the top block.
// Depends on nothing.
package gdp_pkg;

   // Residues are always below the 16-bit modulus.
   localparam int RES_WIDTH = 16;
   // Counter width for one pass over a residue, one bit per cycle.
   localparam int CNT_WIDTH = 4;
   // Modulus after reset.
   localparam logic [RES_WIDTH-1:0] MOD_RESET = 16'd65521;

   typedef logic [RES_WIDTH-1:0] res_type;
   typedef logic [RES_WIDTH:0]   ext_type;
   typedef logic [CNT_WIDTH-1:0] cnt_type;

   // Command from the sequencer to a serial unit.
   typedef struct packed {
      logic    go;
      res_type modulus;
   } unit_cmd_type;

   // One Horner step: (2*acc + dig*addend) mod p, with acc and addend below p.
   function automatic res_type mod_horner(res_type acc, logic dig, res_type addend,
                                          res_type p);
      ext_type dbl;
      ext_type sum;
      dbl = {acc, 1'b0};
      if (dbl >= {1'b0, p}) begin
         dbl = dbl - {1'b0, p};
      end
      sum = dbl + (dig ? {1'b0, addend} : '0);
      if (sum >= {1'b0, p}) begin
         sum = sum - {1'b0, p};
      end
      return sum[RES_WIDTH-1:0];
   endfunction

   // Modular difference of two residues.
   function automatic res_type mod_sub(res_type a, res_type b, res_type p);
      ext_type dif;
      dif = {1'b0, a} - {1'b0, b};
      if (dif[RES_WIDTH]) begin
         dif = dif + {1'b0, p};
      end
      return dif[RES_WIDTH-1:0];
   endfunction

   // Modular sum of two residues.
   function automatic res_type mod_add(res_type a, res_type b, res_type p);
      ext_type sum;
      sum = {1'b0, a} + {1'b0, b};
      if (sum >= {1'b0, p}) begin
         sum = sum - {1'b0, p};
      end
      return sum[RES_WIDTH-1:0];
   endfunction

endpackage

/* src/gdp_reduce.sv */
// Bit-serial reduction of one input field modulo p, MSB first, one bit per cycle.
// Depends on gdp_pkg.
module gdp_reduce #(
   parameter int FIELD_WIDTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  gdp_pkg::unit_cmd_type cmd,
   input  logic [FIELD_WIDTH-1:0] value,
   output logic                  done,
   output gdp_pkg::res_type      result
);
   localparam int CW = $clog2(FIELD_WIDTH + 1);
   localparam logic [CW-1:0] CNT_LOAD = CW'(FIELD_WIDTH);
   localparam logic [CW-1:0] CNT_LAST = CW'(1);

   logic [FIELD_WIDTH-1:0] shift_ff;
   gdp_pkg::res_type       rem_ff;
   gdp_pkg::res_type       rem_in;
   logic [CW-1:0]          cnt_ff;
   logic                   run_ff;
   logic                   done_ff;
   gdp_pkg::ext_type       trial;

   // Shift the next bit into the remainder and subtract p once if needed.
   always_comb begin
      trial = {rem_ff, shift_ff[FIELD_WIDTH-1]};
      if (trial >= {1'b0, cmd.modulus}) begin
         trial = trial - {1'b0, cmd.modulus};
      end
      rem_in = trial[gdp_pkg::RES_WIDTH-1:0];
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.go && !run_ff) begin
            run_ff <= 1'b1;
         end else if (run_ff && cnt_ff == CNT_LAST) begin
            run_ff  <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   // Datapath.
   always_ff @(posedge clock) begin
      if (cmd.go && !run_ff) begin
         shift_ff <= value;
         rem_ff   <= '0;
         cnt_ff   <= CNT_LOAD;
      end else if (run_ff) begin
         shift_ff <= {shift_ff[FIELD_WIDTH-2:0], 1'b0};
         rem_ff   <= rem_in;
         cnt_ff   <= cnt_ff - CNT_LAST;
      end
   end

   assign done   = done_ff;
   assign result = rem_ff;
endmodule

/* src/gdp_modmul.sv */
// Bit-serial modular multiplier: interleaved double-and-add, one multiplier bit per cycle.
// Depends on gdp_pkg.
module gdp_modmul (
   input  logic                  clock,
   input  logic                  reset,
   input  gdp_pkg::unit_cmd_type cmd,
   input  gdp_pkg::res_type      mcand,
   input  gdp_pkg::res_type      mplier,
   output logic                  done,
   output gdp_pkg::res_type      product
);
   gdp_pkg::res_type a_ff;
   gdp_pkg::res_type b_ff;
   gdp_pkg::res_type acc_ff;
   gdp_pkg::cnt_type cnt_ff;
   logic             run_ff;
   logic             done_ff;

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.go && !run_ff) begin
            run_ff <= 1'b1;
         end else if (run_ff && (&cnt_ff)) begin
            run_ff  <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   // Horner accumulation over the multiplier bits, MSB first.
   always_ff @(posedge clock) begin
      if (cmd.go && !run_ff) begin
         a_ff   <= mcand;
         b_ff   <= mplier;
         acc_ff <= '0;
         cnt_ff <= '0;
      end else if (run_ff) begin
         acc_ff <= gdp_pkg::mod_horner(acc_ff, b_ff[gdp_pkg::RES_WIDTH-1], a_ff,
                                       cmd.modulus);
         b_ff   <= {b_ff[gdp_pkg::RES_WIDTH-2:0], 1'b0};
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;
endmodule

/* src/gdp_inv.sv */
// Modular inverse by extended Euclid; each quotient comes from a bit-serial divider
// while q*t1 mod p is accumulated one quotient bit behind. Depends on gdp_pkg.
module gdp_inv (
   input  logic                  clock,
   input  logic                  reset,
   input  gdp_pkg::unit_cmd_type cmd,
   input  gdp_pkg::res_type      value,
   output logic                  done,
   output logic                  ok,
   output gdp_pkg::res_type      inverse
);
   typedef enum logic [4:0] {
      INV_IDLE  = 5'b00001,
      INV_CHECK = 5'b00010,
      INV_DIV   = 5'b00100,
      INV_TAIL  = 5'b01000,
      INV_SWAP  = 5'b10000
   } inv_state_type;

   inv_state_type    state_ff;
   gdp_pkg::res_type r0_ff, r1_ff, t0_ff, t1_ff;
   gdp_pkg::res_type dvd_ff, rem_ff, prod_ff;
   logic             qbit_ff;
   gdp_pkg::cnt_type cnt_ff;
   logic             done_ff;
   logic             ok_ff;
   gdp_pkg::ext_type trial;
   logic             fits;
   gdp_pkg::ext_type rem_new;

   // One restoring division step.
   always_comb begin
      trial   = {rem_ff, dvd_ff[gdp_pkg::RES_WIDTH-1]};
      fits    = (trial >= {1'b0, r1_ff});
      rem_new = fits ? (trial - {1'b0, r1_ff}) : trial;
   end

   // Sequencer.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= INV_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            INV_IDLE: begin
               if (cmd.go) begin
                  state_ff <= INV_CHECK;
               end
            end
            INV_CHECK: begin
               if (r1_ff == '0) begin
                  done_ff  <= 1'b1;
                  state_ff <= INV_IDLE;
               end else begin
                  state_ff <= INV_DIV;
               end
            end
            INV_DIV: begin
               if (&cnt_ff) begin
                  state_ff <= INV_TAIL;
               end
            end
            INV_TAIL: state_ff <= INV_SWAP;
            INV_SWAP: state_ff <= INV_CHECK;
            default:  state_ff <= INV_IDLE;
         endcase
      end
   end

   // Remainder and coefficient datapath.
   always_ff @(posedge clock) begin
      unique case (state_ff)
         INV_IDLE: begin
            if (cmd.go) begin
               r0_ff <= cmd.modulus;
               r1_ff <= value;
               t0_ff <= '0;
               t1_ff <= gdp_pkg::res_type'(1);
            end
         end
         INV_CHECK: begin
            ok_ff   <= (r0_ff == gdp_pkg::res_type'(1));
            dvd_ff  <= r0_ff;
            rem_ff  <= '0;
            prod_ff <= '0;
            qbit_ff <= 1'b0;
            cnt_ff  <= '0;
         end
         INV_DIV: begin
            rem_ff  <= rem_new[gdp_pkg::RES_WIDTH-1:0];
            qbit_ff <= fits;
            dvd_ff  <= {dvd_ff[gdp_pkg::RES_WIDTH-2:0], 1'b0};
            prod_ff <= gdp_pkg::mod_horner(prod_ff, qbit_ff, t1_ff, cmd.modulus);
            cnt_ff  <= cnt_ff + 1'b1;
         end
         INV_TAIL: begin
            prod_ff <= gdp_pkg::mod_horner(prod_ff, qbit_ff, t1_ff, cmd.modulus);
         end
         INV_SWAP: begin
            r0_ff <= r1_ff;
            r1_ff <= rem_ff;
            t0_ff <= t1_ff;
            t1_ff <= gdp_pkg::mod_sub(t0_ff, prod_ff, cmd.modulus);
         end
         default: begin
            cnt_ff <= '0;
         end
      endcase
   end

   assign done    = done_ff;
   assign ok      = ok_ff;
   assign inverse = t0_ff;
endmodule

/* src/genus2_divisor_from_two_points.sv */
// Genus-2 Mumford pair from two points. The block takes one point pair at a time: a
// transfer on start is taken when busy is low, and busy stays high until the result has
// been shown on the rsp_ ports for one cycle with rsp_valid, which the receiver must take
// then. The point pair is captured at the start transfer, so the req_ ports are free
// afterwards. Per item, the input reduction runs one bit per cycle, then up to three
// modular products run on the shared serial multiplier, with the inverse between the
// first and the second; the inverse runs one Euclid step at a time, each quotient from
// a bit-serial divider. A pair without a chord skips the last two products. A modulus
// below two gives zero u and v with rsp_bad_pair set in the cycle right after the start
// transfer.
module genus2_divisor_from_two_points #(
   parameter int FIELD_WIDTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [FIELD_WIDTH-1:0] req_first_x,
   input  logic [FIELD_WIDTH-1:0] req_first_y,
   input  logic [FIELD_WIDTH-1:0] req_second_x,
   input  logic [FIELD_WIDTH-1:0] req_second_y,
   output logic                   busy,
   output logic                   rsp_valid,
   output logic [FIELD_WIDTH-1:0] rsp_u_const,
   output logic [FIELD_WIDTH-1:0] rsp_u_lin,
   output logic [FIELD_WIDTH-1:0] rsp_v_const,
   output logic [FIELD_WIDTH-1:0] rsp_v_slope,
   output logic                   rsp_bad_pair,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [15:0]            csr_data
);
   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_RED    = 9'b000000010,
      ST_PREP   = 9'b000000100,
      ST_UL     = 9'b000001000,
      ST_MUL_UC = 9'b000010000,
      ST_INV    = 9'b000100000,
      ST_MUL_VS = 9'b001000000,
      ST_MUL_VX = 9'b010000000,
      ST_RESP   = 9'b100000000
   } state_type;

   state_type        state_ff, state_in;
   gdp_pkg::res_type modulus_ff;
   logic             red_go_ff, red_go_in;
   logic             mul_go_ff, mul_go_in;
   logic             inv_go_ff, inv_go_in;
   logic [FIELD_WIDTH-1:0] req_x1_ff, req_y1_ff, req_x2_ff, req_y2_ff;
   gdp_pkg::res_type x1_ff, y1_ff, x2_ff, y2_ff;
   gdp_pkg::res_type dx_ff, dy_ff, sum_ff, inv_ff;
   gdp_pkg::res_type uc_ff, ul_ff, vs_ff, vc_ff;
   logic             bad_ff;
   logic [3:0]       red_done;
   gdp_pkg::res_type red_x1, red_y1, red_x2, red_y2;
   logic             mul_done;
   gdp_pkg::res_type mul_a, mul_b, mul_p;
   logic             inv_done, inv_ok;
   gdp_pkg::res_type inv_val;
   gdp_pkg::unit_cmd_type red_cmd, mul_cmd, inv_cmd;

   // Fit a residue into the field width.
   function automatic logic [FIELD_WIDTH-1:0] to_field(gdp_pkg::res_type r);
      logic [FIELD_WIDTH+gdp_pkg::RES_WIDTH-1:0] wide;
      wide = {{FIELD_WIDTH{1'b0}}, r};
      return wide[FIELD_WIDTH-1:0];
   endfunction

   assign red_cmd = '{go: red_go_ff, modulus: modulus_ff};
   assign mul_cmd = '{go: mul_go_ff, modulus: modulus_ff};
   assign inv_cmd = '{go: inv_go_ff, modulus: modulus_ff};

   // Input reduction, all four captured fields side by side.
   gdp_reduce #(.FIELD_WIDTH(FIELD_WIDTH)) u_red_x1 (
      .clock, .reset, .cmd(red_cmd), .value(req_x1_ff), .done(red_done[0]), .result(red_x1));
   gdp_reduce #(.FIELD_WIDTH(FIELD_WIDTH)) u_red_y1 (
      .clock, .reset, .cmd(red_cmd), .value(req_y1_ff), .done(red_done[1]), .result(red_y1));
   gdp_reduce #(.FIELD_WIDTH(FIELD_WIDTH)) u_red_x2 (
      .clock, .reset, .cmd(red_cmd), .value(req_x2_ff), .done(red_done[2]),
      .result(red_x2));
   gdp_reduce #(.FIELD_WIDTH(FIELD_WIDTH)) u_red_y2 (
      .clock, .reset, .cmd(red_cmd), .value(req_y2_ff), .done(red_done[3]),
      .result(red_y2));

   // Shared serial multiplier operands follow the sequencer state.
   always_comb begin
      unique case (state_ff)
         ST_MUL_VS: begin
            mul_a = inv_ff;
            mul_b = dy_ff;
         end
         ST_MUL_VX: begin
            mul_a = x1_ff;
            mul_b = vs_ff;
         end
         default: begin
            mul_a = x1_ff;
            mul_b = x2_ff;
         end
      endcase
   end

   gdp_modmul u_mul (
      .clock, .reset, .cmd(mul_cmd), .mcand(mul_a), .mplier(mul_b),
      .done(mul_done), .product(mul_p));

   gdp_inv u_inv (
      .clock, .reset, .cmd(inv_cmd), .value(dx_ff),
      .done(inv_done), .ok(inv_ok), .inverse(inv_val));

   // Next state and unit launches.
   always_comb begin
      state_in  = state_ff;
      red_go_in = 1'b0;
      mul_go_in = 1'b0;
      inv_go_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (modulus_ff < gdp_pkg::res_type'(2)) begin
                  state_in = ST_RESP;
               end else begin
                  red_go_in = 1'b1;
                  state_in  = ST_RED;
               end
            end
         end
         ST_RED: begin
            if (&red_done) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: state_in = ST_UL;
         ST_UL: begin
            mul_go_in = 1'b1;
            state_in  = ST_MUL_UC;
         end
         ST_MUL_UC: begin
            if (mul_done) begin
               inv_go_in = 1'b1;
               state_in  = ST_INV;
            end
         end
         ST_INV: begin
            if (inv_done) begin
               if (inv_ok) begin
                  mul_go_in = 1'b1;
                  state_in  = ST_MUL_VS;
               end else begin
                  state_in = ST_RESP;
               end
            end
         end
         ST_MUL_VS: begin
            if (mul_done) begin
               mul_go_in = 1'b1;
               state_in  = ST_MUL_VX;
            end
         end
         ST_MUL_VX: begin
            if (mul_done) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers and the modulus register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         red_go_ff  <= 1'b0;
         mul_go_ff  <= 1'b0;
         inv_go_ff  <= 1'b0;
         modulus_ff <= gdp_pkg::MOD_RESET;
      end else begin
         state_ff  <= state_in;
         red_go_ff <= red_go_in;
         mul_go_ff <= mul_go_in;
         inv_go_ff <= inv_go_in;
         if (csr_valid && csr_ready) begin
            modulus_ff <= csr_data;
         end
      end
   end

   // Operand and result registers.
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            uc_ff  <= '0;
            ul_ff  <= '0;
            vs_ff  <= '0;
            vc_ff  <= '0;
            bad_ff <= 1'b1;
            // The point pair is held from the start transfer on.
            if (start) begin
               req_x1_ff <= req_first_x;
               req_y1_ff <= req_first_y;
               req_x2_ff <= req_second_x;
               req_y2_ff <= req_second_y;
            end
         end
         ST_RED: begin
            x1_ff <= red_x1;
            y1_ff <= red_y1;
            x2_ff <= red_x2;
            y2_ff <= red_y2;
         end
         ST_PREP: begin
            dx_ff  <= gdp_pkg::mod_sub(x1_ff, x2_ff, modulus_ff);
            dy_ff  <= gdp_pkg::mod_sub(y1_ff, y2_ff, modulus_ff);
            sum_ff <= gdp_pkg::mod_add(x1_ff, x2_ff, modulus_ff);
         end
         ST_UL: begin
            ul_ff <= gdp_pkg::mod_sub('0, sum_ff, modulus_ff);
         end
         ST_MUL_UC: begin
            if (mul_done) begin
               uc_ff <= mul_p;
            end
         end
         ST_INV: begin
            if (inv_done) begin
               inv_ff <= inv_val;
            end
         end
         ST_MUL_VS: begin
            if (mul_done) begin
               vs_ff <= mul_p;
            end
         end
         ST_MUL_VX: begin
            if (mul_done) begin
               vc_ff  <= gdp_pkg::mod_sub(y1_ff, mul_p, modulus_ff);
               bad_ff <= 1'b0;
            end
         end
         default: begin
            bad_ff <= bad_ff;
         end
      endcase
   end

   // Ports.
   assign busy         = (state_ff != ST_IDLE);
   assign csr_ready    = (state_ff == ST_IDLE);
   assign rsp_valid    = (state_ff == ST_RESP);
   assign rsp_u_const  = to_field(uc_ff);
   assign rsp_u_lin    = to_field(ul_ff);
   assign rsp_v_const  = to_field(vc_ff);
   assign rsp_v_slope  = to_field(vs_ff);
   assign rsp_bad_pair = bad_ff;
endmodule

/* src/gdp_checker.sv */
// Port-level checks for the genus-2 divisor block, attached by bind.
// Depends on genus2_divisor_from_two_points.
module gdp_checker #(
   parameter int FIELD_WIDTH = 16
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input logic                   rsp_valid,
   input logic [FIELD_WIDTH-1:0] rsp_v_const,
   input logic [FIELD_WIDTH-1:0] rsp_v_slope,
   input logic                   rsp_bad_pair,
   input logic                   csr_ready
);
   // A result is shown for a single cycle and then the block is free again.
   a_one_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> (!rsp_valid && !busy))
      else $error("result strobe longer than one cycle");

   // A result only appears while an item is in progress.
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe while idle");

   // A taken start makes the block busy.
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("start transfer not taken");

   // A pair without a chord gives zero for v.
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_bad_pair) |-> (rsp_v_const == '0 && rsp_v_slope == '0))
      else $error("v not zero on bad pair");

   // Configuration is open exactly while idle.
   a_csr_idle: assert property (@(posedge clock) disable iff (reset)
      csr_ready == !busy)
      else $error("configuration ready does not follow idle");
endmodule

bind genus2_divisor_from_two_points gdp_checker #(.FIELD_WIDTH(FIELD_WIDTH)) u_gdp_checker (
   .clock, .reset, .start, .busy, .rsp_valid, .rsp_v_const, .rsp_v_slope,
   .rsp_bad_pair, .csr_ready);
